// ===== hdl/rwrh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrh_pkg
// Shared types, sizes and helpers of the random walk radial histogram block.
// ----------------------------------------------------------------------------
package rwrh_pkg;

  localparam int MAX_STEPS    = 50;
  localparam int COUNT_WIDTH  = 20;
  localparam int BIN_COUNT    = MAX_STEPS * MAX_STEPS + 1;
  localparam int BIN_MAX      = BIN_COUNT - 1;
  localparam int BIN_AW       = $clog2(BIN_COUNT);
  localparam int SUM_WIDTH    = COUNT_WIDTH + BIN_AW;

  localparam int LEN_WIDTH    = 6;
  localparam int DIR_WIDTH    = 3;
  localparam int RADIUS_WIDTH = 10;
  localparam int DIST_WIDTH   = 12;
  localparam int FRAC_BITS    = 16;
  localparam int QUOT_WIDTH   = FRAC_BITS + 1;
  localparam int QCNT_WIDTH   = $clog2(QUOT_WIDTH);

  localparam int POS_WIDTH    = 7;
  localparam int SQ_WIDTH     = 2 * POS_WIDTH;
  localparam int DSUM_WIDTH   = SQ_WIDTH + 2;
  localparam int RSQ_WIDTH    = 2 * RADIUS_WIDTH;
  localparam int NSQ_WIDTH    = 2 * LEN_WIDTH;
  localparam int PROD_WIDTH   = RSQ_WIDTH + NSQ_WIDTH;
  localparam int LIMIT_WIDTH  = PROD_WIDTH - FRAC_BITS;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [LEN_WIDTH-1:0]   WALK_RESET = LEN_WIDTH'(10);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};

  // step direction codes
  localparam logic [DIR_WIDTH-1:0] DIR_NEG_X = 3'd0;
  localparam logic [DIR_WIDTH-1:0] DIR_POS_X = 3'd1;
  localparam logic [DIR_WIDTH-1:0] DIR_POS_Y = 3'd2;
  localparam logic [DIR_WIDTH-1:0] DIR_NEG_Y = 3'd3;
  localparam logic [DIR_WIDTH-1:0] DIR_POS_Z = 3'd4;
  localparam logic [DIR_WIDTH-1:0] DIR_NEG_Z = 3'd5;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic                    command;
    logic [DIR_WIDTH-1:0]    direction;
    logic [RADIUS_WIDTH-1:0] radius;
  } cmd_t;

  typedef struct packed {
    logic                  recorded;
    logic [DIST_WIDTH-1:0] final_distance_sq;
    logic [QUOT_WIDTH-1:0] fraction;
    logic                  empty_res;
  } res_t;

  typedef struct packed {
    logic [2:0] axis;   // one-hot, all zero for an unused direction
    logic       neg;
  } move_t;

  typedef struct packed {
    op_t                  op;
    move_t                move;
    logic [RSQ_WIDTH-1:0] rsq;
  } work_t;

  // out-of-range lengths clamp to 1..MAX_STEPS
  function automatic logic [LEN_WIDTH-1:0] eff_len(input logic [LEN_WIDTH-1:0] len);
    logic [LEN_WIDTH-1:0] n;
    n = len;
    if (n == '0) begin
      n = LEN_WIDTH'(1);
    end else if (n > LEN_WIDTH'(MAX_STEPS)) begin
      n = LEN_WIDTH'(MAX_STEPS);
    end
    return n;
  endfunction

endpackage

// ===== hdl/rwrh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrh_front
// Takes commands, decodes the step direction and squares the query radius,
// then hands the work item to the queue.
// ----------------------------------------------------------------------------
module rwrh_front
  import rwrh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  cmd_t  item,
  input  logic  clearing,
  input  logic  q_full,
  output logic  q_push,
  output work_t q_data
);

  logic  fvalid;
  work_t fwork;
  work_t decoded;
  logic  accept;

  always_comb begin
    decoded      = '0;
    decoded.op   = item.command ? OP_QUERY : OP_STEP;
    decoded.rsq  = RSQ_WIDTH'(item.radius) * RSQ_WIDTH'(item.radius);
    unique case (item.direction)
      DIR_NEG_X: decoded.move = '{axis: 3'b001, neg: 1'b1};
      DIR_POS_X: decoded.move = '{axis: 3'b001, neg: 1'b0};
      DIR_POS_Y: decoded.move = '{axis: 3'b010, neg: 1'b0};
      DIR_NEG_Y: decoded.move = '{axis: 3'b010, neg: 1'b1};
      DIR_POS_Z: decoded.move = '{axis: 3'b100, neg: 1'b0};
      DIR_NEG_Z: decoded.move = '{axis: 3'b100, neg: 1'b1};
      default:   decoded.move = '0;
    endcase
  end

  assign busy   = clearing | (fvalid & q_full);
  assign accept = start & ~busy;
  assign q_push = fvalid & ~q_full;
  assign q_data = fwork;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (accept) begin
      fvalid <= 1'b1;
    end else if (q_push) begin
      fvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwork <= decoded;
    end
  end

endmodule

// ===== hdl/rwrh_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrh_queue
// Short first-in first-out queue of decoded work between front and back.
// ----------------------------------------------------------------------------
module rwrh_queue
  import rwrh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t wdata,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output work_t rdata
);

  work_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + QUEUE_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

// ===== hdl/rwrh_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrh_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den)
// for num <= den.
// ----------------------------------------------------------------------------
module rwrh_div
  import rwrh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_WIDTH-1:0]  num,
  input  logic [SUM_WIDTH-1:0]  den,
  output logic                  done,
  output logic [QUOT_WIDTH-1:0] quot
);

  logic                  active;
  logic [QCNT_WIDTH-1:0] cnt;
  logic [SUM_WIDTH:0]    rem;
  logic [SUM_WIDTH-1:0]  den_r;
  logic                  ge;
  logic [SUM_WIDTH:0]    rem_sel;

  assign ge      = rem >= {1'b0, den_r};
  assign rem_sel = ge ? (rem - {1'b0, den_r}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + QCNT_WIDTH'(1);
        if (cnt == QCNT_WIDTH'(QUOT_WIDTH - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_r <= den;
      quot  <= '0;
    end else if (active) begin
      // remainder stays below den, so one bit of headroom is enough
      rem  <= {rem_sel[SUM_WIDTH-1:0], 1'b0};
      quot <= {quot[QUOT_WIDTH-2:0], ge};
    end
  end

  a_done_after_active: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(active) && !active)
    else $error("divider done without a running division");

endmodule

// ===== hdl/rwrh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrh_back
// Executes work items: walks the particle, bins finished walks into the
// histogram memory, and answers queries by scanning the bins and dividing.
// ----------------------------------------------------------------------------
module rwrh_back
  import rwrh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [LEN_WIDTH-1:0] walk_length,
  input  logic                 q_empty,
  input  work_t                q_head,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 done,
  output res_t                 result
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SQ    = 9'b000000100,
    S_RMW   = 9'b000001000,
    S_QMUL  = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_DCHK  = 9'b010000000,
    S_DIV   = 9'b100000000
  } state_t;

  state_t state;

  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] pos_z;
  logic [LEN_WIDTH-1:0]        steps_taken;
  logic [COUNT_WIDTH-1:0]      particle_total;

  logic [DIST_WIDTH-1:0]  d2;
  logic [RSQ_WIDTH-1:0]   rsq;
  logic [NSQ_WIDTH-1:0]   nsq;
  logic [LIMIT_WIDTH-1:0] limit;
  logic [BIN_AW-1:0]      scan_addr;
  logic                   acc_valid;
  logic [BIN_AW-1:0]      acc_idx;
  logic [SUM_WIDTH-1:0]   total;
  logic [SUM_WIDTH-1:0]   inner;
  logic                   div_start;
  logic                   div_done;
  logic [QUOT_WIDTH-1:0]  div_quot;

  // histogram memory
  logic [COUNT_WIDTH-1:0] hist [BIN_COUNT];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [BIN_AW-1:0]      rd_addr;
  logic [BIN_AW-1:0]      wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   wr_en;

  logic [LEN_WIDTH-1:0]        n;
  logic [LEN_WIDTH-1:0]        steps_inc;
  logic                        walk_end;
  logic signed [POS_WIDTH-1:0] px_next;
  logic signed [POS_WIDTH-1:0] py_next;
  logic signed [POS_WIDTH-1:0] pz_next;
  logic [POS_WIDTH-1:0]        ax;
  logic [POS_WIDTH-1:0]        ay;
  logic [POS_WIDTH-1:0]        az;
  logic [SQ_WIDTH-1:0]         sqx;
  logic [SQ_WIDTH-1:0]         sqy;
  logic [SQ_WIDTH-1:0]         sqz;
  logic [DSUM_WIDTH-1:0]       dsum;
  logic [DIST_WIDTH-1:0]       d2_clamped;
  logic [PROD_WIDTH-1:0]       prod;
  logic [COUNT_WIDTH-1:0]      hist_inc;
  logic [COUNT_WIDTH-1:0]      total_inc;

  function automatic logic signed [POS_WIDTH-1:0] move_axis(
    input logic signed [POS_WIDTH-1:0] p,
    input logic                        sel,
    input logic                        neg
  );
    logic signed [POS_WIDTH-1:0] r;
    r = p;
    if (sel) begin
      r = neg ? (p - POS_WIDTH'(1)) : (p + POS_WIDTH'(1));
    end
    return r;
  endfunction

  assign n         = eff_len(walk_length);
  assign steps_inc = steps_taken + LEN_WIDTH'(1);
  assign walk_end  = steps_inc >= n;
  assign px_next   = move_axis(pos_x, q_head.move.axis[AXIS_X], q_head.move.neg);
  assign py_next   = move_axis(pos_y, q_head.move.axis[AXIS_Y], q_head.move.neg);
  assign pz_next   = move_axis(pos_z, q_head.move.axis[AXIS_Z], q_head.move.neg);

  assign ax   = pos_x[POS_WIDTH-1] ? POS_WIDTH'(-pos_x) : POS_WIDTH'(pos_x);
  assign ay   = pos_y[POS_WIDTH-1] ? POS_WIDTH'(-pos_y) : POS_WIDTH'(pos_y);
  assign az   = pos_z[POS_WIDTH-1] ? POS_WIDTH'(-pos_z) : POS_WIDTH'(pos_z);
  assign sqx  = SQ_WIDTH'(ax) * SQ_WIDTH'(ax);
  assign sqy  = SQ_WIDTH'(ay) * SQ_WIDTH'(ay);
  assign sqz  = SQ_WIDTH'(az) * SQ_WIDTH'(az);
  assign dsum = DSUM_WIDTH'(sqx) + DSUM_WIDTH'(sqy) + DSUM_WIDTH'(sqz);
  assign d2_clamped = (dsum > DSUM_WIDTH'(BIN_MAX)) ? DIST_WIDTH'(BIN_MAX)
                                                     : DIST_WIDTH'(dsum);

  assign prod      = PROD_WIDTH'(rsq) * PROD_WIDTH'(nsq);
  assign hist_inc  = (rd_data >= COUNT_MAX) ? COUNT_MAX : rd_data + COUNT_WIDTH'(1);
  assign total_inc = (particle_total >= COUNT_MAX) ? COUNT_MAX
                                                   : particle_total + COUNT_WIDTH'(1);

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign clearing = (state == S_CLEAR);

  // memory ports: bin lookup while binning, bin sweep otherwise
  assign rd_addr = (state == S_SQ) ? BIN_AW'(d2_clamped) : scan_addr;
  assign wr_en   = (state == S_CLEAR) || (state == S_RMW);
  assign wr_addr = (state == S_RMW) ? BIN_AW'(d2) : scan_addr;
  assign wr_data = (state == S_RMW) ? hist_inc : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[wr_addr] <= wr_data;
    end
    rd_data <= hist[rd_addr];
  end

  rwrh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (inner),
    .den   (total),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      scan_addr      <= '0;
      pos_x          <= '0;
      pos_y          <= '0;
      pos_z          <= '0;
      steps_taken    <= '0;
      particle_total <= '0;
      done           <= 1'b0;
      acc_valid      <= 1'b0;
      div_start      <= 1'b0;
    end else begin
      done      <= 1'b0;
      acc_valid <= 1'b0;
      div_start <= 1'b0;

      // read data arrives in the cycle after its scan address
      if (acc_valid) begin
        total <= total + SUM_WIDTH'(rd_data);
        if (LIMIT_WIDTH'(acc_idx) <= limit) begin
          inner <= inner + SUM_WIDTH'(rd_data);
        end
      end

      unique case (state)
        S_CLEAR: begin
          scan_addr <= scan_addr + BIN_AW'(1);
          if (scan_addr == BIN_AW'(BIN_MAX)) begin
            scan_addr <= '0;
            state     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            if (q_head.op == OP_STEP) begin
              pos_x <= px_next;
              pos_y <= py_next;
              pos_z <= pz_next;
              if (walk_end) begin
                state <= S_SQ;
              end else begin
                steps_taken <= steps_inc;
                done        <= 1'b1;
                result      <= '0;
              end
            end else begin
              rsq   <= q_head.rsq;
              nsq   <= NSQ_WIDTH'(n) * NSQ_WIDTH'(n);
              state <= S_QMUL;
            end
          end
        end
        S_SQ: begin
          d2    <= d2_clamped;
          state <= S_RMW;
        end
        S_RMW: begin
          particle_total <= total_inc;
          pos_x          <= '0;
          pos_y          <= '0;
          pos_z          <= '0;
          steps_taken    <= '0;
          done           <= 1'b1;
          result         <= '{recorded: 1'b1, final_distance_sq: d2,
                              fraction: '0, empty_res: 1'b0};
          state          <= S_IDLE;
        end
        S_QMUL: begin
          limit     <= prod[PROD_WIDTH-1:FRAC_BITS];
          total     <= '0;
          inner     <= '0;
          scan_addr <= '0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          acc_valid <= 1'b1;
          acc_idx   <= scan_addr;
          scan_addr <= scan_addr + BIN_AW'(1);
          if (scan_addr == BIN_AW'(nsq)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DCHK;
        end
        S_DCHK: begin
          if (total == '0) begin
            done   <= 1'b1;
            result <= '{recorded: 1'b0, final_distance_sq: '0,
                        fraction: '0, empty_res: 1'b1};
            state  <= S_IDLE;
          end else begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            done   <= 1'b1;
            result <= '{recorded: 1'b0, final_distance_sq: '0,
                        fraction: div_quot, empty_res: 1'b0};
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_rmw_after_sq: assert property (@(posedge clk) disable iff (rst)
    state == S_RMW |-> $past(state) == S_SQ)
    else $error("histogram write without a preceding bin lookup");

  a_pop_progress: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> done || state == S_SQ || state == S_QMUL)
    else $error("popped item neither finished nor started");

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> particle_total >= $past(particle_total))
    else $error("particle total went down");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    steps_taken < LEN_WIDTH'(MAX_STEPS))
    else $error("step count past the longest walk");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.empty_res |-> result.fraction == '0 && !result.recorded)
    else $error("empty query result carries data");

endmodule

// ===== hdl/random_walk_radial_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_walk_radial_histogram
// Lattice random walk with a radial histogram of walk end points and
// density queries over it.
// ----------------------------------------------------------------------------
// flow: a plain step is registered in the front, passes the queue and strobes done from the
//   executor; a query scans bins 0..n*n, then divides (no divide when empty), n the walk length
// throughput: one plain step per cycle while busy is low; a walk-ending step holds the executor
//   for the histogram lookup and read-modify-write, a query until its result
// reset: busy stays high while the histogram is swept to zero; walk length
//   returns to 10, always writable; results strobe on done, never held off
module random_walk_radial_histogram
  import rwrh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  cmd_t                 item,
  output logic                 done,
  output res_t                 result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LEN_WIDTH-1:0] cfg_data
);

  logic [LEN_WIDTH-1:0] walk_length;
  logic                 clearing;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_push;
  logic                 q_pop;
  work_t                q_in;
  work_t                q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_length <= WALK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      walk_length <= cfg_data;
    end
  end

  rwrh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  rwrh_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_head)
  );

  rwrh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .walk_length (walk_length),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .done        (done),
    .result      (result)
  );

endmodule
